// ----- rtl/core/wetc_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Window equal-triple counter package
// Shared constants and types for the window equal-triple counter.
// ----------------------------------------------------------------------------
package wetc_pkg;

  localparam int VALUE_BITS_DEF = 10;
  localparam int COUNT_BITS_DEF = 16;
  localparam int TOTAL_W        = 48;

  localparam logic OP_ADD    = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_READ  = 4'b0100,
    ST_UPD   = 4'b1000
  } wetc_state_t;

endpackage : wetc_pkg
// ----------------------------------------------------------------------------
`default_nettype wire

// ----- rtl/core/wetc_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module wetc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule : wetc_ram
// ----------------------------------------------------------------------------
`default_nettype wire

// ----- rtl/core/window_equal_triple_counter_unit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Window equal-triple counter
// Keeps a histogram of the values in a sliding window in a RAM and a running
// total of equal-value triples, the sum over bins of C(count,3).
// ----------------------------------------------------------------------------
// After reset the block sweeps the histogram RAM to zero, one bin per cycle,
// so busy stays high until every bin is cleared, and no transaction is taken
// before then. Each transaction then passes in order through the histogram
// RAM read, the pair-count multiplication and the write-back and total
// update. The result is shown on out_valid for
// exactly one cycle, and the receiver cannot stall it; a new transaction may
// start in that same cycle. An add to a full bin or a removal from an empty
// bin leaves the state unchanged and reports out_error.
// ----------------------------------------------------------------------------
module window_equal_triple_counter_unit
  import wetc_pkg::*;
#(
  parameter int VALUE_BITS = VALUE_BITS_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic                  in_op,
  input  wire logic [VALUE_BITS-1:0] in_value,
  output logic                       out_valid,
  output logic      [TOTAL_W-1:0]    out_triple_count,
  output logic                       out_error
);

  localparam int DEPTH  = 1 << VALUE_BITS;
  localparam int PROD_W = 2 * COUNT_BITS;

  wetc_state_t             state_r, state_nxt;
  logic [VALUE_BITS-1:0]   clr_addr_r, clr_addr_nxt;
  logic [VALUE_BITS-1:0]   addr_r;
  logic                    op_r;
  logic [PROD_W-1:0]       prod_r;
  logic [COUNT_BITS-1:0]   cnt_new_r;
  logic                    err_pend_r;
  logic [TOTAL_W-1:0]      total_r, total_nxt;
  logic                    out_valid_r;
  logic                    out_error_r;

  logic                    accept;
  logic [COUNT_BITS-1:0]   rd_cnt;
  logic [COUNT_BITS-1:0]   k;
  logic [COUNT_BITS-1:0]   k_m1;
  logic                    cnt_full;
  logic                    cnt_empty;
  logic [TOTAL_W-1:0]      pairs;
  logic                    ram_we;
  logic [VALUE_BITS-1:0]   ram_waddr;
  logic [COUNT_BITS-1:0]   ram_wdata;

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;

  wetc_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (DEPTH)
  ) u_hist_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (accept),
    .raddr (in_value),
    .rdata (rd_cnt)
  );

  assign cnt_full  = &rd_cnt;
  assign cnt_empty = (rd_cnt == '0);
  assign k         = (op_r == OP_REMOVE) ? rd_cnt - COUNT_BITS'(1) : rd_cnt;
  assign k_m1      = k - COUNT_BITS'(1);
  assign pairs     = TOTAL_W'(prod_r >> 1);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = addr_r;
    ram_wdata = cnt_new_r;
    if (state_r == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr_r;
      ram_wdata = '0;
    end else if (state_r == ST_UPD) begin
      ram_we = !err_pend_r;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    clr_addr_nxt = clr_addr_r;
    total_nxt    = total_r;
    unique case (state_r)
      ST_CLEAR: begin
        clr_addr_nxt = clr_addr_r + VALUE_BITS'(1);
        if (&clr_addr_r) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        state_nxt = ST_UPD;
      end
      ST_UPD: begin
        state_nxt = ST_IDLE;
        if (!err_pend_r) begin
          total_nxt = (op_r == OP_REMOVE) ? total_r - pairs : total_r + pairs;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_addr_r  <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      total_r     <= total_nxt;
      out_valid_r <= (state_r == ST_UPD);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      addr_r <= in_value;
      op_r   <= in_op;
    end
    if (state_r == ST_READ) begin
      prod_r     <= PROD_W'(k) * PROD_W'(k_m1);
      cnt_new_r  <= (op_r == OP_REMOVE) ? rd_cnt - COUNT_BITS'(1)
                                        : rd_cnt + COUNT_BITS'(1);
      err_pend_r <= (op_r == OP_REMOVE) ? cnt_empty : cnt_full;
    end
    if (state_r == ST_UPD) begin
      out_error_r <= err_pend_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_triple_count = total_r;
  assign out_error        = out_error_r;

  a_result_follows_start: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##3 out_valid)
    else $error("Transaction did not produce a result three cycles after start.");

  a_result_single_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("Result strobe held for more than one cycle.");

  a_idle_with_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("Result shown while the block is still busy.");

  a_error_keeps_total: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_error) |-> $stable(out_triple_count))
    else $error("Rejected transaction changed the triple total.");

endmodule : window_equal_triple_counter_unit
// ----------------------------------------------------------------------------
`default_nettype wire
